### sv/tef_pkg.sv
// ----------------------------------------------------------------------------
// tef_pkg
// Shared types and constants of the tilt equalizer: register map, the
// configuration bundle, and the command/status structs between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tef_pkg;

  // coefficient format: signed Q7.24
  localparam int unsigned COEF_FRAC = 24;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MONO_MODE     = 3'd0;
  localparam logic [2:0] REG_LOWPASS_FEED  = 3'd1;
  localparam logic [2:0] REG_LOWPASS_FB    = 3'd2;
  localparam logic [2:0] REG_LOW_GAIN      = 3'd3;
  localparam logic [2:0] REG_HIGH_GAIN     = 3'd4;
  localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd5;

  // reset value of output gain: unity in Q7.24
  localparam logic signed [31:0] OUTPUT_GAIN_RESET = 32'sd16777216;

  // half an lsb of the coefficient scale, added before the shift
  localparam logic signed [63:0] ROUND_HALF = 64'sd8388608;

  // 32-bit signed limits at accumulator width
  localparam logic signed [41:0] S32_MAX = 42'sd2147483647;
  localparam logic signed [41:0] S32_MIN = -42'sd2147483648;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic               mono;
    logic signed [31:0] feed;
    logic signed [31:0] feedback;
    logic signed [31:0] low_gain;
    logic signed [31:0] high_gain;
    logic signed [31:0] out_gain;
  } cfg_t;

  // multiplier operand pair
  typedef enum logic [2:0] {
    MUL_FEED_X,
    MUL_FB_LP,
    MUL_LOW_L,
    MUL_HIGH_HP,
    MUL_OUT_PRE
  } mul_sel_e;

  // accumulator / register update
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_X,
    OP_ACC_LOAD,
    OP_LP_UPDATE,
    OP_HIGHPASS,
    OP_PRE_LOAD,
    OP_PRE_SAT,
    OP_STORE_Y
  } alu_op_e;

  typedef struct packed {
    logic     take_in;
    logic     push;
    logic     chan;
    mul_sel_e mul_sel;
    alu_op_e  alu_op;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

  // saturate an accumulator value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/tef_ctrl.sv
// ----------------------------------------------------------------------------
// tef_ctrl
// Sequencer of the tilt equalizer: walks one channel through the shared
// multiplier schedule, repeats for the right channel in stereo mode, then
// hands the result pair to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tef_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            mono_i,
  input  wire tef_pkg::status_t status_i,
  output tef_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_X,
    ST_MUL_FEED,
    ST_MUL_FB,
    ST_ACC,
    ST_LP_UPD,
    ST_MUL_LOW,
    ST_MUL_HIGH,
    ST_PRE_LOAD,
    ST_PRE_SAT,
    ST_MUL_OUT,
    ST_WAIT_OUT,
    ST_STORE,
    ST_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   chan_q, chan_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_d        = state_q;
    chan_d         = chan_q;
    cmd_o.take_in  = 1'b0;
    cmd_o.push     = 1'b0;
    cmd_o.chan     = chan_q;
    cmd_o.mul_sel  = tef_pkg::MUL_FEED_X;
    cmd_o.alu_op   = tef_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          chan_d        = 1'b0;
          state_d       = ST_LOAD_X;
        end
      end
      ST_LOAD_X: begin
        cmd_o.alu_op = tef_pkg::OP_LOAD_X;
        state_d      = ST_MUL_FEED;
      end
      ST_MUL_FEED: begin
        cmd_o.mul_sel = tef_pkg::MUL_FEED_X;
        state_d       = ST_MUL_FB;
      end
      ST_MUL_FB: begin
        cmd_o.mul_sel = tef_pkg::MUL_FB_LP;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.alu_op = tef_pkg::OP_ACC_LOAD;
        state_d      = ST_LP_UPD;
      end
      ST_LP_UPD: begin
        cmd_o.alu_op = tef_pkg::OP_LP_UPDATE;
        state_d      = ST_MUL_LOW;
      end
      ST_MUL_LOW: begin
        cmd_o.mul_sel = tef_pkg::MUL_LOW_L;
        cmd_o.alu_op  = tef_pkg::OP_HIGHPASS;
        state_d       = ST_MUL_HIGH;
      end
      ST_MUL_HIGH: begin
        cmd_o.mul_sel = tef_pkg::MUL_HIGH_HP;
        state_d       = ST_PRE_LOAD;
      end
      ST_PRE_LOAD: begin
        cmd_o.alu_op = tef_pkg::OP_PRE_LOAD;
        state_d      = ST_PRE_SAT;
      end
      ST_PRE_SAT: begin
        cmd_o.alu_op = tef_pkg::OP_PRE_SAT;
        state_d      = ST_MUL_OUT;
      end
      ST_MUL_OUT: begin
        cmd_o.mul_sel = tef_pkg::MUL_OUT_PRE;
        state_d       = ST_WAIT_OUT;
      end
      ST_WAIT_OUT: begin
        state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.alu_op = tef_pkg::OP_STORE_Y;
        if (!mono_i && !chan_q) begin
          chan_d  = 1'b1;
          state_d = ST_LOAD_X;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status_i.slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

endmodule

`default_nettype wire

### sv/tef_datapath.sv
// ----------------------------------------------------------------------------
// tef_datapath
// One shared 32x32 multiplier with registered product and rounding stage,
// an accumulator, the two lowpass state registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tef_datapath #(
  parameter int unsigned SampleWidth = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tef_pkg::cmd_t          cmd_i,
  input  wire tef_pkg::cfg_t          cfg_i,
  input  wire logic [SampleWidth-1:0] left_in_i,
  input  wire logic [SampleWidth-1:0] right_in_i,
  input  wire logic                   out_ready_i,
  output tef_pkg::status_t            status_o,
  output logic                        out_valid_o,
  output logic [SampleWidth-1:0]      left_out_o,
  output logic [SampleWidth-1:0]      right_out_o
);

  // output saturation limits at rounded-product width
  localparam logic signed [39:0] Y_MAX = {{(41 - SampleWidth){1'b0}}, {(SampleWidth - 1){1'b1}}};
  localparam logic signed [39:0] Y_MIN = ~Y_MAX;

  logic signed [SampleWidth-1:0] xl_q, xr_q;
  logic signed [SampleWidth:0]   pair_sum;
  logic signed [SampleWidth-1:0] avg;
  logic signed [SampleWidth-1:0] x_sel;
  logic signed [31:0]            x_q;
  logic signed [31:0]            lp_l_q, lp_r_q, lp_cur;
  logic signed [31:0]            l_q, hp_q, pre_q;
  logic signed [31:0]            mul_a, mul_b;
  logic signed [63:0]            prod_q, rnd_sum;
  logic signed [39:0]            rnd_q;
  logic signed [41:0]            acc_q;
  logic signed [41:0]            lp_sum, hp_diff, pre_sum;
  logic signed [31:0]            l_new;
  logic signed [SampleWidth-1:0] y_sat;
  logic [SampleWidth-1:0]        y_l_q, y_r_q;
  logic                          out_valid_q;
  logic [SampleWidth-1:0]        out_l_q, out_r_q;

  // mono average with floor
  assign pair_sum = {xl_q[SampleWidth-1], xl_q} + {xr_q[SampleWidth-1], xr_q};
  assign avg      = pair_sum[SampleWidth:1];
  assign x_sel    = cfg_i.mono ? avg : (cmd_i.chan ? xr_q : xl_q);
  assign lp_cur   = cmd_i.chan ? lp_r_q : lp_l_q;

  // multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      tef_pkg::MUL_FEED_X: begin
        mul_a = cfg_i.feed;
        mul_b = x_q;
      end
      tef_pkg::MUL_FB_LP: begin
        mul_a = cfg_i.feedback;
        mul_b = lp_cur;
      end
      tef_pkg::MUL_LOW_L: begin
        mul_a = cfg_i.low_gain;
        mul_b = l_q;
      end
      tef_pkg::MUL_HIGH_HP: begin
        mul_a = cfg_i.high_gain;
        mul_b = hp_q;
      end
      tef_pkg::MUL_OUT_PRE: begin
        mul_a = cfg_i.out_gain;
        mul_b = pre_q;
      end
      default: begin
        mul_a = cfg_i.feed;
        mul_b = x_q;
      end
    endcase
  end

  // round half up to the value scale
  assign rnd_sum = prod_q + tef_pkg::ROUND_HALF;

  // accumulator side arithmetic
  assign lp_sum  = acc_q + 42'(rnd_q);
  assign l_new   = tef_pkg::sat32(lp_sum);
  assign hp_diff = 42'(x_q) - 42'(l_q);
  assign pre_sum = acc_q + 42'(rnd_q);

  // final saturation to sample width
  always_comb begin
    if (rnd_q > Y_MAX) begin
      y_sat = Y_MAX[SampleWidth-1:0];
    end else if (rnd_q < Y_MIN) begin
      y_sat = Y_MIN[SampleWidth-1:0];
    end else begin
      y_sat = rnd_q[SampleWidth-1:0];
    end
  end

  // multiplier and rounding pipeline
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    rnd_q  <= rnd_sum[63:tef_pkg::COEF_FRAC];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      xl_q <= left_in_i;
      xr_q <= right_in_i;
    end
    case (cmd_i.alu_op)
      tef_pkg::OP_LOAD_X:   x_q   <= 32'(x_sel);
      tef_pkg::OP_ACC_LOAD: acc_q <= 42'(rnd_q);
      tef_pkg::OP_LP_UPDATE: l_q  <= l_new;
      tef_pkg::OP_HIGHPASS: hp_q  <= tef_pkg::sat32(hp_diff);
      tef_pkg::OP_PRE_LOAD: acc_q <= 42'(x_q) + 42'(rnd_q);
      tef_pkg::OP_PRE_SAT:  pre_q <= tef_pkg::sat32(pre_sum);
      tef_pkg::OP_STORE_Y: begin
        if (cmd_i.chan) begin
          y_r_q <= y_sat;
        end else begin
          y_l_q <= y_sat;
          if (cfg_i.mono) begin
            y_r_q <= y_sat;
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.push) begin
      out_l_q <= y_l_q;
      out_r_q <= y_r_q;
    end
  end

  // lowpass state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_l_q <= '0;
      lp_r_q <= '0;
    end else if (cmd_i.alu_op == tef_pkg::OP_LP_UPDATE) begin
      if (cmd_i.chan) begin
        lp_r_q <= l_new;
      end else begin
        lp_l_q <= l_new;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign left_out_o         = out_l_q;
  assign right_out_o        = out_r_q;

endmodule

`default_nettype wire

### sv/tilt_equalizer_filter.sv
// ----------------------------------------------------------------------------
// tilt_equalizer_filter
// Stereo tilt equalizer: per channel one-pole lowpass, low and high band
// gains, output gain and saturation, with an optional mono mode.
// ----------------------------------------------------------------------------
// One sample pair is worked through a single shared 32x32 multiplier, five
// products per channel; stereo runs the channels one after the other through
// the schedule, mono runs one pass for both. The next item is accepted once
// the result pair is pushed, a push waiting while the output register holds
// an untaken result. The input side is free again while a finished pair sits
// in the output register. Coefficients are written over the APB port while
// the block is idle, a rule for the user that the block does not enforce.
// Registers lie at byte addresses 0x00 (mono_mode), 0x04 (lowpass_feed),
// 0x08 (lowpass_feedback), 0x0C (low_band_gain), 0x10 (high_band_gain) and
// 0x14 (output_gain), all signed Q7.24 except mono_mode.
`default_nettype none

module tilt_equalizer_filter #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  localparam int unsigned TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input item: left_in, right_in
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  // result item: left_out, right_out
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  tef_pkg::cfg_t    cfg_q;
  tef_pkg::cmd_t    cmd;
  tef_pkg::status_t status;
  logic [2:0]       reg_idx;
  logic             cfg_wr;
  logic [SAMPLE_WIDTH-1:0] left_out, right_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mono      <= 1'b0;
      cfg_q.feed      <= '0;
      cfg_q.feedback  <= '0;
      cfg_q.low_gain  <= '0;
      cfg_q.high_gain <= '0;
      cfg_q.out_gain  <= tef_pkg::OUTPUT_GAIN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        tef_pkg::REG_MONO_MODE:    cfg_q.mono      <= pwdata[0];
        tef_pkg::REG_LOWPASS_FEED: cfg_q.feed      <= pwdata;
        tef_pkg::REG_LOWPASS_FB:   cfg_q.feedback  <= pwdata;
        tef_pkg::REG_LOW_GAIN:     cfg_q.low_gain  <= pwdata;
        tef_pkg::REG_HIGH_GAIN:    cfg_q.high_gain <= pwdata;
        tef_pkg::REG_OUTPUT_GAIN:  cfg_q.out_gain  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      tef_pkg::REG_MONO_MODE:    prdata = {31'd0, cfg_q.mono};
      tef_pkg::REG_LOWPASS_FEED: prdata = cfg_q.feed;
      tef_pkg::REG_LOWPASS_FB:   prdata = cfg_q.feedback;
      tef_pkg::REG_LOW_GAIN:     prdata = cfg_q.low_gain;
      tef_pkg::REG_HIGH_GAIN:    prdata = cfg_q.high_gain;
      tef_pkg::REG_OUTPUT_GAIN:  prdata = cfg_q.out_gain;
      default:                   prdata = '0;
    endcase
  end

  tef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mono_i     (cfg_q.mono),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tef_datapath #(
    .SampleWidth (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .left_in_i   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .right_in_i  (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .left_out_o  (left_out),
    .right_out_o (right_out)
  );

  assign m_axis_tdata = TDATA_W'({right_out, left_out});

  // a result is only pushed into a free or draining output register
  a_push_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result pushed over a pending output");

  // once an item is taken the input side stays closed for the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // mono results are identical on both channels
  a_mono_equal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && cfg_q.mono) |->
      (m_axis_tdata[SAMPLE_WIDTH-1:0] == m_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]))
    else $error("mono result differs between channels");

endmodule

`default_nettype wire

### tb/sv/tilt_equalizer_filter_tb.sv
// ----------------------------------------------------------------------------
// tilt_equalizer_filter_tb
// Self-checking bench for the tilt equalizer. Sample pairs go in over the
// input stream and coefficients over the APB port. A scoreboard keeps its own
// copy of the coefficients and both lowpass states, works out every filtered
// pair and compares it field by field with what leaves the output stream.
// ----------------------------------------------------------------------------
module tilt_equalizer_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tef_pkg::*;

  localparam int unsigned SW      = 24;
  localparam int unsigned TDATA_W = 48;

  // byte address 4 * index, index 6 has no register behind it
  localparam logic [2:0] REG_UNMAPPED = 3'd6;

  localparam logic [23:0] S_MAX = 24'h7f_ffff;
  localparam logic [23:0] S_MIN = 24'h80_0000;
  localparam logic [23:0] S_ONE = 24'h00_0001;
  localparam logic [23:0] S_NEG = 24'hff_ffff;
  localparam logic [31:0] C_MAX = 32'h7fff_ffff;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] UNITY = 32'h0100_0000;

  // left sample in the low bits, right sample above it
  typedef struct packed {
    logic [23:0] right;
    logic [23:0] left;
  } pair_t;

  // tracks coefficients and lowpass states, holds the pairs still to come
  class tilt_scoreboard;
    logic   mono;
    longint feed, feedback, low_gain, high_gain, out_gain;
    longint lp_left, lp_right;
    pair_t  expected_q[$];
    int     n_in, n_out, n_bad;

    function new();
      mono      = 1'b0;
      feed      = 0;
      feedback  = 0;
      low_gain  = 0;
      high_gain = 0;
      out_gain  = longint'(OUTPUT_GAIN_RESET);
      lp_left   = 0;
      lp_right  = 0;
      n_in      = 0;
      n_out     = 0;
      n_bad     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      longint s;
      s = {{32{value[31]}}, value};
      case (idx)
        REG_MONO_MODE:    mono = value[0];
        REG_LOWPASS_FEED: feed = s;
        REG_LOWPASS_FB:   feedback = s;
        REG_LOW_GAIN:     low_gain = s;
        REG_HIGH_GAIN:    high_gain = s;
        REG_OUTPUT_GAIN:  out_gain = s;
        default: ;
      endcase
    endfunction

    // exact product, round half up back to the value scale
    function longint scale(longint coef, longint val);
      return (coef * val + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function longint clamp(longint v, int unsigned w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // one-pole lowpass plus band gains for one channel
    function longint run_channel(longint x, bit right_ch);
      longint lp, l, hp, pre;
      lp = right_ch ? lp_right : lp_left;
      l  = clamp(scale(feed, x) + scale(feedback, lp), 32);
      if (right_ch) lp_right = l;
      else lp_left = l;
      hp  = clamp(x - l, 32);
      pre = clamp(x + scale(low_gain, l) + scale(high_gain, hp), 32);
      return clamp(scale(out_gain, pre), SW);
    endfunction

    function void note_input(pair_t p);
      longint xl, xr, yl, yr;
      pair_t  e;
      xl = {{40{p.left[23]}}, p.left};
      xr = {{40{p.right[23]}}, p.right};
      // mono: floor of the average, right state stays untouched
      if (mono) begin
        yl = run_channel((xl + xr) >>> 1, 1'b0);
        yr = yl;
      end else begin
        yl = run_channel(xl, 1'b0);
        yr = run_channel(xr, 1'b1);
      end
      e.left  = yl[23:0];
      e.right = yr[23:0];
      expected_q.push_back(e);
      n_in++;
    endfunction

    function void check_result(pair_t got);
      pair_t e;
      n_out++;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: result item with nothing pending, left %h right %h",
                   got.left, got.right);
        return;
      end
      e = expected_q.pop_front();
      if (got.left !== e.left) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: item %0d left_out expected %h got %h", n_out, e.left,
                   got.left);
      end
      if (got.right !== e.right) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: item %0d right_out expected %h got %h", n_out, e.right,
                   got.right);
      end
    endfunction
  endclass

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               s_valid = 1'b0;
  logic [TDATA_W-1:0] s_data  = '0;
  logic               m_ready = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [4:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  wire                s_ready;
  wire                m_valid;
  wire [TDATA_W-1:0]  m_data;
  wire [31:0]         prdata;
  wire                pready;

  tilt_scoreboard eq_model = new();
  int tx_idle_pct  = 20;
  int rx_idle_pct  = 85;
  int hold_request = 0;
  int n_writes     = 0;

  tilt_equalizer_filter #(
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // hard limit on run time
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: check accepted items, random backpressure, long hold on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_valid === 1'b1 && m_ready) eq_model.check_result(pair_t'(m_data));
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // offer one sample pair, with random gaps ahead of it
  task automatic send_pair(input logic [23:0] left, input logic [23:0] right);
    pair_t p;
    p.left  = left;
    p.right = right;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= p;
    do @(posedge clk); while (s_ready !== 1'b1);
    eq_model.note_input(p);
  endtask

  // stop offering and wait until every pending pair has come back
  task automatic drain();
    s_valid <= 1'b0;
    while (eq_model.expected_q.size() != 0) @(posedge clk);
  endtask

  // apb write, setup then access; the bus is released by the caller
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    eq_model.write_reg(idx, value);
    n_writes++;
  endtask

  task automatic configure(input logic [31:0] mono_word, input logic [31:0] feed,
                           input logic [31:0] feedback, input logic [31:0] low_gain,
                           input logic [31:0] high_gain, input logic [31:0] out_gain);
    write_reg(REG_MONO_MODE, mono_word);
    write_reg(REG_LOWPASS_FEED, feed);
    write_reg(REG_LOWPASS_FB, feedback);
    write_reg(REG_LOW_GAIN, low_gain);
    write_reg(REG_HIGH_GAIN, high_gain);
    write_reg(REG_OUTPUT_GAIN, out_gain);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly the typical value, sometimes a rail or anything at all
  function automatic logic [31:0] pick_coef(input logic [31:0] typical);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return C_MAX;
    if (sel == 1) return C_MIN;
    if (sel == 2) return $urandom();
    return typical;
  endfunction

  function automatic logic [23:0] rand_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
    if (sel == 1) return 24'($urandom_range(0, 64)) - 24'd32;
    return 24'($urandom());
  endfunction

  // stimulus
  initial begin
    logic [31:0] feed_t, fb_t, lo_t, hi_t, og_t;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: output equals input
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '0);
    send_pair(S_ONE, S_NEG);
    send_pair(24'h55_5555, 24'haa_aaaa);
    drain();

    // mono with positive and negative rails, upper mono bits set, write to a hole
    write_reg(REG_UNMAPPED, C_MAX);
    configure(32'h8000_0001, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MAX, S_MIN);
    send_pair(S_NEG, '0);
    send_pair(S_ONE, '0);
    drain();

    // stereo with the opposite rails; right state untouched by the mono run
    configure(32'hffff_fffe, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair('0, '0);
    send_pair(S_ONE, S_NEG);
    drain();

    // plain lowpass: highpass cancelled, unity output, step response
    configure('0, 32'h0010_0000, 32'h00f0_0000, '0, 32'hff00_0000, UNITY);
    repeat (6) send_pair(S_MAX, S_MIN);

    // random settings and samples, idling pattern changing over the phases
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      if (ph < 4) begin
        tx_idle_pct = 20;
        rx_idle_pct = 85;
      end else if (ph < 7) begin
        tx_idle_pct = 85;
        rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      feed_t = $urandom_range(0, UNITY);
      fb_t   = UNITY - feed_t - $urandom_range(0, 4096);
      lo_t   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
      hi_t   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
      og_t   = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      configure($urandom(), pick_coef(feed_t), pick_coef(fb_t), pick_coef(lo_t),
                pick_coef(hi_t), pick_coef(og_t));
      // output side held off long enough for the input to back up
      if (ph == 7) hold_request = 300;
      repeat (75) send_pair(rand_sample(), rand_sample());
    end
    drain();
    repeat (40) @(posedge clk);

    $display("summary: %0d sample pairs, %0d register writes, stereo and mono,", eq_model.n_in,
             n_writes);
    $display("summary: coefficient rails, long output hold, %0d results, %0d mismatches",
             eq_model.n_out, eq_model.n_bad);
    if (eq_model.n_bad == 0 && eq_model.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/tef_pkg.sv
sv/tef_ctrl.sv
sv/tef_datapath.sv
sv/tilt_equalizer_filter.sv
tb/sv/tilt_equalizer_filter_tb.sv
